[rtl/core/wroc_pkg.sv]
package wroc_pkg;

	localparam int DEPTH_DEF = 64;

	typedef enum logic [2:0] {
		REG_TIME_WINDOW    = 3'd0,
		REG_WINDOW_SAMPLES = 3'd1,
		REG_WINDOW_FRAMES  = 3'd2,
		REG_OUTPUT_UNIT    = 3'd3,
		REG_SAMPLE_RATE    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		UNIT_MS  = 2'd0,
		UNIT_SEC = 2'd1,
		UNIT_MIN = 2'd2,
		UNIT_HR  = 2'd3
	} unit_t;

	typedef enum logic [2:0] {
		W_IDLE,
		W_TRIM,
		W_READ,
		W_CHECK,
		W_EMIT
	} win_state_t;

	typedef enum logic [2:0] {
		R_IDLE,
		R_MUL,
		R_SCALE,
		R_DIV,
		R_DONE
	} rate_state_t;

	typedef struct packed {
		logic        time_window;
		logic [6:0]  window_samples;
		logic [31:0] window_frames;
		logic [1:0]  output_unit;
		logic [18:0] sample_rate;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic [31:0]        stamp;
	} item_t;

	typedef struct packed {
		logic signed [16:0] dx;
		logic [31:0]        span;
		logic [6:0]         held;
	} job_t;

	localparam logic [47:0] RATE_MAX_POS = 48'h7FFF_FFFF_FFFF;
	localparam logic [63:0] RATE_MAX_NEG = 64'h0000_8000_0000_0000;

	function automatic logic [11:0] unit_mul(input logic [1:0] unit);
		logic [11:0] m;
		unique case (unit)
			UNIT_MIN: m = 12'd60;
			UNIT_HR:  m = 12'd3600;
			default:  m = 12'd1;
		endcase
		return m;
	endfunction

	function automatic logic [9:0] unit_div(input logic [1:0] unit);
		logic [9:0] d;
		unique case (unit)
			UNIT_MS: d = 10'd1000;
			default: d = 10'd1;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/windowed_rate_of_change_unit.sv]
// channel   dir  beat payload
// s_t*      in   signal, elapsed_frames
// m_t*      out  rate (Q.16), samples_held, span_frames
// cfg_*     in   register write, no handshake
//
// After an input beat, when nothing is dropped, m_tvalid rises after these steps: append, trim
// check, oldest read and check, hand-off, multiply, scale, 64 divide steps, output load.
// Each dropped sample adds a trim step in count mode and a read and check in time mode.
// The divider sets the rate: the back end takes no new job until the result is loaded.
// Reset clears the window, the frame clock and the registers to their defaults.
// A two-entry queue takes new beats until it is full while the back end works or m_tready is low.
module windowed_rate_of_change_unit #(
	parameter int DEPTH = wroc_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // signal[15:0], elapsed_frames[31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // rate[47:0], samples_held[54:48], span_frames[86:55]
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	wroc_pkg::cfg_t  cfg_q;
	wroc_pkg::item_t push_item;
	wroc_pkg::item_t q_head;
	wroc_pkg::job_t  job;
	logic            push;
	logic            full;
	logic            q_valid;
	logic            q_pop;
	logic            job_valid;
	logic            job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_window    <= 1'b0;
			cfg_q.window_samples <= 7'd8;
			cfg_q.window_frames  <= 32'd48000;
			cfg_q.output_unit    <= wroc_pkg::UNIT_SEC;
			cfg_q.sample_rate    <= 19'd48000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wroc_pkg::REG_TIME_WINDOW:    cfg_q.time_window    <= cfg_wdata[0];
				wroc_pkg::REG_WINDOW_SAMPLES: cfg_q.window_samples <= cfg_wdata[6:0];
				wroc_pkg::REG_WINDOW_FRAMES:  cfg_q.window_frames  <= cfg_wdata;
				wroc_pkg::REG_OUTPUT_UNIT:    cfg_q.output_unit    <= cfg_wdata[1:0];
				wroc_pkg::REG_SAMPLE_RATE:    cfg_q.sample_rate    <= cfg_wdata[18:0];
				default: ;
			endcase
		end
	end

	wroc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	wroc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	wroc_window #(.DEPTH(DEPTH)) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	wroc_rate u_rate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);
endmodule

[rtl/core/wroc_front.sv]
module wroc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          in_data,
	output logic                 push,
	output wroc_pkg::item_t      push_item,
	input  logic                 full
);
	logic [31:0] total_q;
	logic [31:0] total_next;

	assign in_ready   = !full;
	assign push       = in_valid && !full;
	assign total_next = total_q + {16'd0, in_data[31:16]};

	always_comb begin
		push_item.value = $signed(in_data[15:0]);
		push_item.stamp = total_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (push) begin
			total_q <= total_next;
		end
	end
endmodule

[rtl/core/wroc_queue.sv]
module wroc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wroc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output wroc_pkg::item_t head
);
	wroc_pkg::item_t entry_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign head  = entry_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

[rtl/core/wroc_window.sv]
module wroc_window #(
	parameter int DEPTH = wroc_pkg::DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  wroc_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  wroc_pkg::item_t q_head,
	output logic            q_pop,
	output logic            job_valid,
	input  logic            job_ready,
	output wroc_pkg::job_t  job
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (CW > 7) ? CW : 7;

	wroc_pkg::win_state_t state_q, state_d;

	logic signed [15:0] mem_val_q  [DEPTH];
	logic [31:0]        mem_time_q [DEPTH];

	logic [AW-1:0]      oldest_q;
	logic [CW-1:0]      held_q;
	logic signed [15:0] cur_v_q;
	logic [31:0]        cur_t_q;
	logic signed [15:0] rd_v_q;
	logic [31:0]        rd_t_q;
	wroc_pkg::job_t     job_q;

	logic [AW:0]        slot_sum;
	logic [AW-1:0]      app_slot;
	logic [AW-1:0]      oldest_inc;
	logic [6:0]         cap;
	logic               full;
	logic               over_cap;
	logic [31:0]        span;
	logic               too_wide;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [15:0] wr_val;
	logic [31:0]        wr_time;

	assign slot_sum   = {1'b0, oldest_q} + (AW+1)'(held_q);
	assign app_slot   = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
	                                                 : AW'(slot_sum);
	assign oldest_inc = (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + AW'(1);
	assign cap        = (cfg.window_samples < 7'd2) ? 7'd2 : cfg.window_samples;
	assign full       = held_q == CW'(DEPTH);
	assign over_cap   = KW'(held_q) > KW'(cap);
	assign span       = cur_t_q - rd_t_q;
	assign too_wide   = cfg.time_window && (span > cfg.window_frames);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wroc_pkg::W_IDLE:  if (q_valid) state_d = wroc_pkg::W_TRIM;
			wroc_pkg::W_TRIM: begin
				if (cfg.time_window || !over_cap) state_d = wroc_pkg::W_READ;
			end
			wroc_pkg::W_READ:  state_d = wroc_pkg::W_CHECK;
			wroc_pkg::W_CHECK: begin
				if (too_wide && held_q > CW'(2)) begin
					state_d = wroc_pkg::W_READ;
				end else begin
					state_d = wroc_pkg::W_EMIT;
				end
			end
			wroc_pkg::W_EMIT:  if (job_ready) state_d = wroc_pkg::W_IDLE;
			default: state_d = wroc_pkg::W_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		job_valid = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = app_slot;
		wr_val    = cur_v_q;
		wr_time   = cur_t_q;
		unique case (state_q)
			wroc_pkg::W_IDLE: begin
				q_pop   = q_valid;
				wr_en   = q_valid;
				wr_val  = q_head.value;
				wr_time = q_head.stamp;
			end
			wroc_pkg::W_TRIM: begin
				wr_en = cfg.time_window && held_q == CW'(1);
			end
			wroc_pkg::W_CHECK: begin
				wr_en   = too_wide && !(held_q > CW'(2));
				wr_addr = oldest_q;
				wr_time = cur_t_q - cfg.window_frames;
			end
			wroc_pkg::W_EMIT:  job_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_val_q[wr_addr]  <= wr_val;
			mem_time_q[wr_addr] <= wr_time;
		end
		if (state_q == wroc_pkg::W_READ) begin
			rd_v_q <= mem_val_q[oldest_q];
			rd_t_q <= mem_time_q[oldest_q];
		end
		if (state_q == wroc_pkg::W_IDLE && q_valid) begin
			cur_v_q <= q_head.value;
			cur_t_q <= q_head.stamp;
		end
		if (state_q == wroc_pkg::W_CHECK) begin
			job_q.held <= 7'(held_q);
			if (too_wide) begin
				job_q.dx   <= '0;
				job_q.span <= cfg.window_frames;
			end else begin
				job_q.dx   <= 17'(cur_v_q) - 17'(rd_v_q);
				job_q.span <= span;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wroc_pkg::W_IDLE;
			oldest_q <= '0;
			held_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				wroc_pkg::W_IDLE: begin
					if (q_valid) begin
						if (full) begin
							oldest_q <= oldest_inc;
						end else begin
							held_q <= held_q + CW'(1);
						end
					end
				end
				wroc_pkg::W_TRIM: begin
					if (!cfg.time_window && over_cap) begin
						oldest_q <= oldest_inc;
						held_q   <= held_q - CW'(1);
					end else if (cfg.time_window && held_q == CW'(1)) begin
						held_q <= CW'(2);
					end
				end
				wroc_pkg::W_CHECK: begin
					if (too_wide && held_q > CW'(2)) begin
						oldest_q <= oldest_inc;
						held_q   <= held_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign job = job_q;

`ifndef NO_ASSERTIONS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(DEPTH)) else $error("held count above depth");
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wroc_pkg::W_EMIT |-> held_q != '0) else $error("emit with empty ring");
	a_pop_one: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == wroc_pkg::W_TRIM) else $error("pop outside idle");
`endif
endmodule

[rtl/core/wroc_rate.sv]
module wroc_rate (
	input  logic           clk,
	input  logic           arst_n,
	input  wroc_pkg::cfg_t cfg,
	input  logic           job_valid,
	output logic           job_ready,
	input  wroc_pkg::job_t job,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [87:0]    out_data
);
	wroc_pkg::rate_state_t state_q, state_d;

	logic [15:0] mag_q;
	logic        neg_q;
	logic        zero_q;
	logic [31:0] span_q;
	logic [6:0]  held_q;
	logic [34:0] p1_q;
	logic [41:0] den_q;
	logic [63:0] dvd_q;
	logic [42:0] rem_q;
	logic [5:0]  cnt_q;
	logic        out_valid_q;
	logic [87:0] out_data_q;

	logic [16:0] dx_abs;
	logic [46:0] num;
	logic [42:0] trial;
	logic        take;
	logic [63:0] q;
	logic [63:0] q_neg;
	logic [47:0] rate;
	logic        load_out;

	assign dx_abs   = job.dx[16] ? 17'(-job.dx) : 17'(job.dx);
	assign num      = 47'(p1_q) * 47'(wroc_pkg::unit_mul(cfg.output_unit));
	assign trial    = {rem_q[41:0], dvd_q[63]};
	assign take     = trial >= {1'b0, den_q};
	assign q        = zero_q ? 64'd0 : dvd_q;
	assign q_neg    = (q > wroc_pkg::RATE_MAX_NEG) ? wroc_pkg::RATE_MAX_NEG : q;
	assign load_out = state_q == wroc_pkg::R_DONE && (!out_valid_q || out_ready);

	always_comb begin
		if (neg_q) begin
			rate = 48'd0 - q_neg[47:0];
		end else if (q > 64'(wroc_pkg::RATE_MAX_POS)) begin
			rate = wroc_pkg::RATE_MAX_POS;
		end else begin
			rate = q[47:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wroc_pkg::R_IDLE:  if (job_valid) state_d = wroc_pkg::R_MUL;
			wroc_pkg::R_MUL:   state_d = wroc_pkg::R_SCALE;
			wroc_pkg::R_SCALE: state_d = wroc_pkg::R_DIV;
			wroc_pkg::R_DIV:   if (cnt_q == 6'd63) state_d = wroc_pkg::R_DONE;
			wroc_pkg::R_DONE:  if (load_out) state_d = wroc_pkg::R_IDLE;
			default: state_d = wroc_pkg::R_IDLE;
		endcase
	end

	always_comb begin
		job_ready = state_q == wroc_pkg::R_IDLE;
		out_valid = out_valid_q;
		out_data  = out_data_q;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			wroc_pkg::R_IDLE: begin
				mag_q  <= dx_abs[15:0];
				neg_q  <= job.dx[16];
				zero_q <= job.span == 32'd0;
				span_q <= job.span;
				held_q <= job.held;
			end
			wroc_pkg::R_MUL: begin
				p1_q  <= 35'(mag_q) * 35'(cfg.sample_rate);
				den_q <= 42'(span_q) * 42'(wroc_pkg::unit_div(cfg.output_unit));
			end
			wroc_pkg::R_SCALE: begin
				dvd_q <= {1'b0, num, 16'd0} + 64'(den_q >> 1);
				rem_q <= '0;
				cnt_q <= '0;
			end
			wroc_pkg::R_DIV: begin
				rem_q <= take ? trial - {1'b0, den_q} : trial;
				dvd_q <= {dvd_q[62:0], take};
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
		if (load_out) begin
			out_data_q <= {1'b0, span_q, held_q, rate};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wroc_pkg::R_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wroc_pkg::R_DIV |=> state_q == wroc_pkg::R_DIV || state_q == wroc_pkg::R_DONE)
		else $error("divider left early");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == wroc_pkg::R_DONE)
		else $error("result without finished division");
	a_rem_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wroc_pkg::R_DONE |-> zero_q || rem_q < {1'b0, den_q})
		else $error("remainder not reduced");
`endif
endmodule
